### hdl/crc32_key_partitioner_macros.svh
// ---------------------------------------------------------------------------
// crc32_key_partitioner assertion macros
// shared concurrent assertion forms for the partitioner modules
// ---------------------------------------------------------------------------
`ifndef CRC32_KEY_PARTITIONER_MACROS_SVH
`define CRC32_KEY_PARTITIONER_MACROS_SVH

// same-cycle implication under reset
`define CKP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define CKP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ckp_pkg.sv
// ---------------------------------------------------------------------------
// ckp_pkg
// constants, types and the byte-wise crc fold for the key partitioner
// ---------------------------------------------------------------------------
package ckp_pkg;

    localparam int BYTE_W  = 8;
    localparam int CRC_W   = 32;
    localparam int PCOUNT_W = 16;

    localparam logic [CRC_W-1:0]    CRC_POLY_REFL = 32'hEDB88320;
    localparam logic [CRC_W-1:0]    CRC_INIT      = 32'hFFFFFFFF;
    localparam logic [CRC_W-1:0]    CRC_XOROUT    = 32'hFFFFFFFF;
    localparam logic [PCOUNT_W-1:0] PCOUNT_RESET  = 16'd4;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    typedef struct packed {
        logic full;
        logic empty;
    } ckp_q_status_t;

    // eight reflected shift steps for one byte
    function automatic logic [CRC_W-1:0] fold_byte(input logic [CRC_W-1:0] crc_in,
                                                   input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] crc;
        crc = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (crc[0])
                crc = (crc >> 1) ^ CRC_POLY_REFL;
            else
                crc = crc >> 1;
        end
        return crc;
    endfunction

endpackage

### hdl/ckp_front.sv
// ---------------------------------------------------------------------------
// ckp_front
// takes key bytes, runs the crc and pushes the hash magnitude at key end
// ---------------------------------------------------------------------------
module ckp_front
    import ckp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [BYTE_W-1:0]   key_byte,
    input  logic                key_end,
    input  logic                in_valid,
    output logic                in_ready,
    input  ckp_q_status_t       q_status,
    output logic                q_push,
    output logic [CRC_W-1:0]    q_data
);

    logic [CRC_W-1:0] crc_reg;
    logic [CRC_W-1:0] crc_next;
    logic [CRC_W-1:0] crc_fold;
    logic [CRC_W-1:0] sum;
    logic             accept;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign crc_fold = fold_byte(crc_reg, key_byte);
    assign sum      = crc_fold ^ CRC_XOROUT;

    // magnitude of the signed checksum, 80000000 stays as 2^31
    assign q_data = sum[CRC_W-1] ? (~sum + {{(CRC_W-1){1'b0}}, 1'b1}) : sum;
    assign q_push = accept && key_end;

    always_comb
    begin
        crc_next = crc_reg;
        if (accept)
            crc_next = key_end ? CRC_INIT : crc_fold;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= CRC_INIT;
        else
            crc_reg <= crc_next;
    end

endmodule

### hdl/ckp_queue.sv
// ---------------------------------------------------------------------------
// ckp_queue
// short fifo of hash magnitudes between the crc front and the modulo unit
// ---------------------------------------------------------------------------
`include "crc32_key_partitioner_macros.svh"

module ckp_queue
    import ckp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [CRC_W-1:0] push_data,
    input  logic             pop,
    output logic [CRC_W-1:0] pop_data,
    output ckp_q_status_t    status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
    localparam logic [PTR_W-1:0] PTR_ONE   = PTR_W'(1);

    logic [CRC_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == CNT_DEPTH);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_ONE;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_ONE;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_ONE;
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_ONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    `CKP_ASSERT_IMPL(a_no_push_full, clk, rst_n, status.full, !push, "push into full queue")
    `CKP_ASSERT_IMPL(a_no_pop_empty, clk, rst_n, status.empty, !pop, "pop from empty queue")
    `CKP_ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, count_reg <= CNT_DEPTH,
        "queue count beyond depth")
    `CKP_ASSERT_NEXT(a_ptr_track, clk, rst_n, do_push && !do_pop && !status.full,
        count_reg != '0, "queue count lost a push")

endmodule

### hdl/ckp_mod.sv
// ---------------------------------------------------------------------------
// ckp_mod
// bit-serial modulo of the hash magnitude by the partition count
// ---------------------------------------------------------------------------
`include "crc32_key_partitioner_macros.svh"

module ckp_mod
    import ckp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ckp_q_status_t       q_status,
    input  logic [CRC_W-1:0]    q_data,
    output logic                q_pop,
    input  logic [PCOUNT_W-1:0] pcount,
    output logic [PCOUNT_W-1:0] partition,
    output logic                out_valid,
    input  logic                out_ready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } state_t;

    localparam int CNT_W = $clog2(CRC_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CRC_W - 1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    state_t              state_reg;
    state_t              state_next;
    logic [CRC_W-1:0]    dividend_reg;
    logic [CRC_W-1:0]    dividend_next;
    logic [PCOUNT_W-1:0] div_reg;
    logic [PCOUNT_W-1:0] div_next;
    logic [PCOUNT_W-1:0] rem_reg;
    logic [PCOUNT_W-1:0] rem_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [PCOUNT_W-1:0] partition_reg;
    logic [PCOUNT_W-1:0] partition_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_free;
    logic [PCOUNT_W:0]   shifted;
    logic [PCOUNT_W+1:0] trial;

    assign out_free  = !out_valid_reg || out_ready;
    assign partition = partition_reg;
    assign out_valid = out_valid_reg;
    assign q_pop     = (state_reg == S_IDLE) && !q_status.empty;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    assign shifted = {rem_reg, dividend_reg[CRC_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, div_reg};

    always_comb
    begin
        state_next     = state_reg;
        dividend_next  = dividend_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        partition_next = partition_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_status.empty)
                begin
                    dividend_next = q_data;
                    div_next      = pcount;
                    rem_next      = '0;
                    cnt_next      = '0;
                    // zero partition count skips the run state and gives partition 0
                    state_next    = (pcount == '0) ? S_HOLD : S_RUN;
                end
            end
            S_RUN:
            begin
                rem_next      = trial[PCOUNT_W+1] ? shifted[PCOUNT_W-1:0]
                                                  : trial[PCOUNT_W-1:0];
                dividend_next = {dividend_reg[CRC_W-2:0], 1'b0};
                cnt_next      = cnt_reg + CNT_ONE;
                if (cnt_reg == CNT_LAST)
                    state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    partition_next = rem_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            dividend_reg  <= '0;
            div_reg       <= '0;
            rem_reg       <= '0;
            partition_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            dividend_reg  <= dividend_next;
            div_reg       <= div_next;
            rem_reg       <= rem_next;
            partition_reg <= partition_next;
        end
    end

    `CKP_ASSERT_IMPL(a_rem_below_div, clk, rst_n, state_reg == S_RUN && div_reg != '0,
        rem_reg < div_reg, "remainder not below divisor")
    `CKP_ASSERT_NEXT(a_hold_delivers, clk, rst_n, state_reg == S_HOLD && out_free,
        out_valid_reg && state_reg == S_IDLE, "finished item not moved to output")
    `CKP_ASSERT_IMPL(a_pop_only_idle, clk, rst_n, q_pop, state_reg == S_IDLE,
        "queue popped while busy")
    `CKP_ASSERT_NEXT(a_zero_div, clk, rst_n, state_reg == S_IDLE && q_pop && pcount == '0,
        state_reg == S_HOLD && rem_reg == '0, "zero partition count not handled")

endmodule

### hdl/crc32_key_partitioner.sv
// result path: queue, modulo run and hold states, output register; a zero count skips run
// throughput: one key byte per cycle at the input; the bit-serial modulo unit
// works on one key at a time, and a short queue holds the keys waiting
// for it, so bursts of short keys stall the input once the queue is full
// reset: asynchronous, active low; crc back to all ones, partition count to 4
// ---------------------------------------------------------------------------
// crc32_key_partitioner
// crc-32 hash of streamed keys, as a signed magnitude reduced modulo a configured partition count
// ---------------------------------------------------------------------------
module crc32_key_partitioner
    import ckp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [BYTE_W-1:0]   key_byte,
    input  logic                key_end,
    input  logic                in_valid,
    output logic                in_ready,
    output logic [PCOUNT_W-1:0] partition,
    output logic                out_valid,
    input  logic                out_ready,
    input  logic [PCOUNT_W-1:0] cfg_data,
    input  logic                cfg_valid,
    output logic                cfg_ready
);

    ckp_q_status_t       q_status;
    logic                q_push;
    logic                q_pop;
    logic [CRC_W-1:0]    q_push_data;
    logic [CRC_W-1:0]    q_pop_data;
    logic [PCOUNT_W-1:0] pcount_reg;
    logic [PCOUNT_W-1:0] pcount_next;

    assign cfg_ready   = 1'b1;
    assign pcount_next = (cfg_valid && cfg_ready) ? cfg_data : pcount_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pcount_reg <= PCOUNT_RESET;
        else
            pcount_reg <= pcount_next;
    end

    ckp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .key_byte (key_byte),
        .key_end  (key_end),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .q_status (q_status),
        .q_push   (q_push),
        .q_data   (q_push_data)
    );

    ckp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .status    (q_status)
    );

    ckp_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_data    (q_pop_data),
        .q_pop     (q_pop),
        .pcount    (pcount_reg),
        .partition (partition),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

endmodule
